// File: rtl/core/fkx_pkg.sv
package fkx_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_K      = 32;
    localparam int DEF_COUNT_BITS = 40;

    // Fixed widths of the channel payloads and the configuration register.
    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 6;
    localparam int KMER_BITS_W = 64;
    localparam int COUNT_OUT_W = 40;
    localparam int SEQ_LEN_W   = 32;
    localparam int STATUS_W    = 3;

    localparam logic [CFG_W-1:0] KMER_LEN_RESET = 6'd31;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Characters with a structural meaning in the text.
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;

    // Parser mode of the front end.
    typedef enum logic [1:0] {
        MODE_PRE,
        MODE_HEADER,
        MODE_SEQ
    } t_mode;

    // Status codes reported with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_BASE   = 3'd0,
        ST_SEP    = 3'd1,
        ST_DEGEN  = 3'd2,
        ST_UNEXP  = 3'd3,
        ST_HEADER = 3'd4,
        ST_PRE    = 3'd5
    } t_status;

    // Operations handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_OPEN,
        OP_PRE,
        OP_HEADER,
        OP_SEP,
        OP_BASE,
        OP_DEGEN,
        OP_UNEXP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] base;
    } t_item;

endpackage

// File: rtl/core/fkx_if.sv
// Byte channel into the block.
interface fkx_char_if import fkx_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

// Result channel out of the block.
interface fkx_kmer_if import fkx_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   kmer_valid;
    logic [KMER_BITS_W-1:0] kmer_bits;
    logic [COUNT_OUT_W-1:0] absolute_count;
    logic [COUNT_OUT_W-1:0] sequence_count;
    logic [STATUS_W-1:0]    status;
    logic                   skipped_flag;

    modport source (
        output valid, output kmer_valid, output kmer_bits, output absolute_count,
        output sequence_count, output status, output skipped_flag, input ready
    );
    modport sink (
        input valid, input kmer_valid, input kmer_bits, input absolute_count,
        input sequence_count, input status, input skipped_flag, output ready
    );
endinterface

// File: rtl/core/fkx_front.sv
module fkx_front import fkx_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fkx_char_if.sink     i_char,
    output t_item        o_item,
    output logic         o_item_valid,
    input  logic         i_item_ready
);

    t_mode r_mode;
    t_mode n_mode;
    logic  r_line_start;
    logic  n_line_start;
    logic  accept;
    logic  is_base;
    logic  is_degen;
    logic  is_sep;
    logic  [1:0] base_code;
    logic  [CHAR_W-1:0] ch;

    assign ch           = i_char.char_byte;
    assign i_char.ready = i_item_ready;
    assign o_item_valid = i_char.valid;
    assign accept       = i_char.valid && i_item_ready;

    // Base letters in either case map to their 2-bit code.
    always_comb begin
        is_base   = 1'b1;
        base_code = 2'd0;
        unique case (ch) inside
            8'h41, 8'h61: base_code = 2'd0;
            8'h43, 8'h63: base_code = 2'd1;
            8'h47, 8'h67: base_code = 2'd2;
            8'h54, 8'h74: base_code = 2'd3;
            default:      is_base   = 1'b0;
        endcase
    end

    // Degeneracy letters W S P Y K M B D H V N in either case.
    always_comb begin
        unique case (ch) inside
            8'h57, 8'h77, 8'h53, 8'h73, 8'h50, 8'h70, 8'h59, 8'h79,
            8'h4B, 8'h6B, 8'h4D, 8'h6D, 8'h42, 8'h62, 8'h44, 8'h64,
            8'h48, 8'h68, 8'h56, 8'h76, 8'h4E, 8'h6E: is_degen = 1'b1;
            default:                                  is_degen = 1'b0;
        endcase
    end

    assign is_sep = (ch == CH_NL) || (ch == CH_SPACE) || (ch == CH_DOT) || (ch == CH_DASH);

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PRE;
            r_line_start <= 1'b1;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_line_start <= n_line_start;
        end
    end

    // Classification of the byte and the next parser state.
    always_comb begin
        n_mode       = r_mode;
        n_line_start = (ch == CH_NL);
        o_item.op    = OP_UNEXP;
        o_item.base  = base_code;
        if (r_mode != MODE_HEADER && r_line_start && ch == CH_GT) begin
            n_mode       = MODE_HEADER;
            n_line_start = 1'b0;
            o_item.op    = OP_OPEN;
        end else begin
            unique case (r_mode)
                MODE_PRE: begin
                    o_item.op = OP_PRE;
                end
                MODE_HEADER: begin
                    o_item.op = OP_HEADER;
                    if (ch == CH_NL) begin
                        n_mode = MODE_SEQ;
                    end
                end
                MODE_SEQ: begin
                    if (is_sep) begin
                        o_item.op = OP_SEP;
                    end else if (is_base) begin
                        o_item.op = OP_BASE;
                    end else if (is_degen) begin
                        o_item.op = OP_DEGEN;
                    end else begin
                        o_item.op = OP_UNEXP;
                    end
                end
                default: begin
                    n_mode    = MODE_PRE;
                    o_item.op = OP_PRE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/fkx_queue.sv
module fkx_queue import fkx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_push_item,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    output t_item o_pop_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Entry storage; the pointers wrap since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/fkx_back.sv
module fkx_back import fkx_pkg::*; #(
    parameter int MAX_K      = DEF_MAX_K,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_kmer_length,
    input  t_item            i_item,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    fkx_kmer_if.source       o_kmer
);

    localparam int WIN_W  = 2 * MAX_K;
    localparam int FILL_W = $clog2(MAX_K + 1);
    localparam int EXT_W  = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

    // Sequence state.
    logic [WIN_W-1:0]      r_window;
    logic [WIN_W-1:0]      n_window;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     n_fill;
    logic [SEQ_LEN_W-1:0]  r_seq_len;
    logic [SEQ_LEN_W-1:0]  n_seq_len;
    logic [COUNT_BITS-1:0] r_counter;
    logic [COUNT_BITS-1:0] n_counter;
    logic [COUNT_BITS-1:0] r_offset;
    logic [COUNT_BITS-1:0] n_offset;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_kvalid;
    logic                   n_out_kvalid;
    logic [KMER_BITS_W-1:0] r_out_bits;
    logic [KMER_BITS_W-1:0] n_out_bits;
    logic [COUNT_OUT_W-1:0] r_out_abs;
    logic [COUNT_OUT_W-1:0] r_out_seq;
    t_status                r_out_status;
    t_status                n_out_status;
    logic                   r_out_skip;
    logic                   n_out_skip;

    logic [FILL_W-1:0]     k_eff;
    logic [FILL_W-1:0]     fill_step;
    logic [SEQ_LEN_W-1:0]  seq_step;
    logic                  seq_reach;
    logic [COUNT_BITS-1:0] cnt_step;
    logic [COUNT_BITS-1:0] seq_diff;
    logic [EXT_W-1:0]      abs_ext;
    logic [EXT_W-1:0]      seq_ext;
    logic [WIN_W-1:0]      win_mask;
    logic                  pop;

    assign o_item_ready = !r_out_valid || o_kmer.ready;
    assign pop          = i_item_valid && o_item_ready;

    // Effective k: zero acts as one, values above the window depth clip to it.
    always_comb begin
        if (i_kmer_length == '0) begin
            k_eff = FILL_W'(1);
        end else if (int'(i_kmer_length) > MAX_K) begin
            k_eff = FILL_W'(MAX_K);
        end else begin
            k_eff = FILL_W'(i_kmer_length);
        end
    end

    // Low 2k bits of the window form the k-mer.
    always_comb begin
        for (int i = 0; i < WIN_W; i++) begin
            win_mask[i] = (i < 2 * int'(k_eff));
        end
    end

    // Saturating position counts for a base or degeneracy letter.
    assign seq_step  = (r_seq_len == '1) ? r_seq_len : r_seq_len + 1'b1;
    assign seq_reach = (seq_step >= SEQ_LEN_W'(k_eff));
    assign cnt_step  = (seq_reach && r_counter != '1) ? r_counter + 1'b1 : r_counter;
    assign fill_step = (r_fill >= k_eff) ? k_eff : r_fill + 1'b1;

    // Execution of one operation.
    always_comb begin
        n_window     = r_window;
        n_fill       = r_fill;
        n_seq_len    = r_seq_len;
        n_counter    = r_counter;
        n_offset     = r_offset;
        n_out_kvalid = 1'b0;
        n_out_skip   = 1'b0;
        n_out_status = ST_UNEXP;
        unique case (i_item.op)
            OP_OPEN: begin
                n_window     = '0;
                n_fill       = '0;
                n_seq_len    = '0;
                n_offset     = r_counter;
                n_out_status = ST_HEADER;
            end
            OP_PRE:    n_out_status = ST_PRE;
            OP_HEADER: n_out_status = ST_HEADER;
            OP_SEP:    n_out_status = ST_SEP;
            OP_BASE: begin
                n_window     = (r_window << 2) | WIN_W'(i_item.base);
                n_fill       = fill_step;
                n_seq_len    = seq_step;
                n_counter    = cnt_step;
                n_out_kvalid = (fill_step == k_eff);
                n_out_skip   = (fill_step < k_eff) && seq_reach;
                n_out_status = ST_BASE;
            end
            OP_DEGEN: begin
                n_window     = '0;
                n_fill       = '0;
                n_seq_len    = seq_step;
                n_counter    = cnt_step;
                n_out_skip   = seq_reach;
                n_out_status = ST_DEGEN;
            end
            default:   n_out_status = ST_UNEXP;
        endcase
    end

    assign n_out_bits = n_out_kvalid ? KMER_BITS_W'(n_window & win_mask) : '0;
    assign seq_diff   = n_counter - n_offset;
    assign abs_ext    = EXT_W'(n_counter);
    assign seq_ext    = EXT_W'(seq_diff);

    // Sequence state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_fill    <= '0;
            r_seq_len <= '0;
            r_counter <= '0;
            r_offset  <= '0;
        end else if (pop) begin
            r_window  <= n_window;
            r_fill    <= n_fill;
            r_seq_len <= n_seq_len;
            r_counter <= n_counter;
            r_offset  <= n_offset;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (o_kmer.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_kvalid <= n_out_kvalid;
            r_out_bits   <= n_out_bits;
            r_out_abs    <= abs_ext[COUNT_OUT_W-1:0];
            r_out_seq    <= seq_ext[COUNT_OUT_W-1:0];
            r_out_status <= n_out_status;
            r_out_skip   <= n_out_skip;
        end
    end

    assign o_kmer.valid          = r_out_valid;
    assign o_kmer.kmer_valid     = r_out_kvalid;
    assign o_kmer.kmer_bits      = r_out_bits;
    assign o_kmer.absolute_count = r_out_abs;
    assign o_kmer.sequence_count = r_out_seq;
    assign o_kmer.status         = r_out_status;
    assign o_kmer.skipped_flag   = r_out_skip;

endmodule

// File: rtl/core/fasta_kmer_extractor.sv
// Channel   Dir  Handshake      Payload
// i_char    in   valid/ready    char_byte
// o_kmer    out  valid/ready    kmer_valid, kmer_bits, absolute_count,
//                               sequence_count, status, skipped_flag
// i_cfg     in   write enable   kmer_length (6 bits)
//
// One byte can be taken every cycle while the queue has room; each transfer in gives one transfer out.
// A byte is written into the front-end queue and then loads the output
// register, from which its result transfers.
// Synchronous active-low reset returns the parser to before the first header,
// clears the window and counters, and sets k to 31.
// A stalled result side fills the output register and the two-entry queue,
// then i_char.ready drops; it rises again once the next result transfer frees a queue entry.
module fasta_kmer_extractor import fkx_pkg::*; #(
    parameter int MAX_K      = DEF_MAX_K,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    fkx_char_if.sink         i_char,
    fkx_kmer_if.source       o_kmer
);

    logic [CFG_W-1:0] r_kmer_length;
    t_item            front_item;
    logic             front_valid;
    logic             front_ready;
    t_item            back_item;
    logic             back_valid;
    logic             back_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= KMER_LEN_RESET;
        end else if (i_cfg_we) begin
            r_kmer_length <= i_cfg_wdata;
        end
    end

    // Parser and classifier.
    fkx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    // Decoupling queue.
    fkx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_item  (front_item),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_pop_item   (back_item),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready)
    );

    // Window, counters and result register.
    fkx_back #(
        .MAX_K      (MAX_K),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kmer_length (r_kmer_length),
        .i_item        (back_item),
        .i_item_valid  (back_valid),
        .o_item_ready  (back_ready),
        .o_kmer        (o_kmer)
    );

`ifndef SYNTHESIS
    // A full k-mer is only reported for a base.
    a_kmer_on_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kmer.valid && o_kmer.kmer_valid) |-> (o_kmer.status == ST_BASE))
        else $error("k-mer reported for a non-base byte");

    // Window bits are cleared when no k-mer is reported.
    a_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kmer.valid && !o_kmer.kmer_valid) |-> (o_kmer.kmer_bits == '0))
        else $error("k-mer bits nonzero without a k-mer");

    // A skipped position goes with a base or degeneracy letter and no k-mer.
    a_skip_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kmer.valid && o_kmer.skipped_flag) |->
            (!o_kmer.kmer_valid &&
             (o_kmer.status == ST_BASE || o_kmer.status == ST_DEGEN)))
        else $error("skipped flag on a wrong result");

    // Header bytes always see an in-sequence count of zero.
    a_header_seq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kmer.valid && o_kmer.status == ST_HEADER) |-> (o_kmer.sequence_count == '0))
        else $error("sequence count nonzero in a header");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
    import fkx_pkg::*;

    // Phase plan and run limits.
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_BYTES = 180;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = '1;
    localparam logic [SEQ_LEN_W-1:0]   SEQ_MAX   = '1;

    typedef struct packed {
        logic                   kmer_valid;
        logic [KMER_BITS_W-1:0] kmer_bits;
        logic [COUNT_OUT_W-1:0] absolute_count;
        logic [COUNT_OUT_W-1:0] sequence_count;
        t_status                status;
        logic                   skipped_flag;
    } t_kmer_res;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              drain;
    } t_text_byte;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    fkx_char_if byte_ch ();
    fkx_kmer_if kmer_ch ();

    fasta_kmer_extractor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (byte_ch),
        .o_kmer      (kmer_ch)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent and k-mer results waiting to arrive.
    t_text_byte text_q[$];
    t_kmer_res  kmer_exp_q[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_grant = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Parser state of the predictor.
    logic [CFG_W-1:0]       klen;
    t_mode                  p_mode;
    logic                   p_line_start;
    logic [KMER_BITS_W-1:0] p_window;
    int unsigned            p_fill;
    logic [SEQ_LEN_W-1:0]   p_seq_len;
    logic [COUNT_OUT_W-1:0] p_counter;
    logic [COUNT_OUT_W-1:0] p_offset;

    // Works out the result of one byte and advances the parser state.
    function automatic t_kmer_res scan_byte(input logic [CHAR_W-1:0] c);
        t_kmer_res   r;
        int unsigned k;
        logic        counted;
        logic        is_base;
        logic        is_degen;
        logic [1:0]  code;
        logic [KMER_BITS_W-1:0] wmask;
        r = '0;
        counted = 1'b0;
        code = 2'd0;
        k = (klen == 0) ? 1 : ((klen > DEF_MAX_K) ? DEF_MAX_K : klen);
        wmask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        is_base = 1'b1;
        case (c)
            "A", "a": code = 2'd0;
            "C", "c": code = 2'd1;
            "G", "g": code = 2'd2;
            "T", "t": code = 2'd3;
            default: is_base = 1'b0;
        endcase
        case (c)
            "W", "w", "S", "s", "P", "p", "Y", "y", "K", "k", "M", "m",
            "B", "b", "D", "d", "H", "h", "V", "v", "N", "n": is_degen = 1'b1;
            default: is_degen = 1'b0;
        endcase

        if (p_mode != MODE_HEADER && p_line_start && c == CH_GT) begin
            // A header opens: restart the sequence and note the offset.
            p_mode = MODE_HEADER;
            p_window = '0;
            p_fill = 0;
            p_seq_len = '0;
            p_offset = p_counter;
            p_line_start = 1'b0;
            r.status = ST_HEADER;
        end else if (p_mode == MODE_PRE) begin
            p_line_start = (c == CH_NL);
            r.status = ST_PRE;
        end else if (p_mode == MODE_HEADER) begin
            if (c == CH_NL) begin
                p_mode = MODE_SEQ;
            end
            p_line_start = (c == CH_NL);
            r.status = ST_HEADER;
        end else begin
            p_line_start = (c == CH_NL);
            if (c == CH_NL || c == CH_SPACE || c == CH_DOT || c == CH_DASH) begin
                r.status = ST_SEP;
            end else if (is_base || is_degen) begin
                if (is_base) begin
                    p_window = {p_window[KMER_BITS_W-3:0], code};
                    p_fill = (p_fill >= k) ? k : p_fill + 1;
                    r.status = ST_BASE;
                end else begin
                    p_window = '0;
                    p_fill = 0;
                    r.status = ST_DEGEN;
                end
                if (p_seq_len != SEQ_MAX) begin
                    p_seq_len = p_seq_len + 1'b1;
                end
                if (p_seq_len >= k && p_counter != COUNT_MAX) begin
                    p_counter = p_counter + 1'b1;
                end
                counted = 1'b1;
                r.kmer_valid = is_base && (p_fill >= k);
            end else begin
                r.status = ST_UNEXP;
            end
        end

        r.kmer_bits = r.kmer_valid ? (p_window & wmask) : '0;
        r.absolute_count = p_counter;
        r.sequence_count = p_counter - p_offset;
        r.skipped_flag = counted && (p_fill < k) && (p_seq_len >= k);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Byte driver: takes a transfer, predicts it, then offers the next byte.
    always @(posedge i_clk) begin : drive_bytes
        t_kmer_res r;
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                r = scan_byte(byte_ch.char_byte);
                kmer_exp_q.push_back(r);
                text_q.delete(0);
            end
            // A byte offered but not taken stays on the channel unchanged.
            if (!(byte_ch.valid && !byte_ch.ready)) begin
                if (text_q.size() > 0 && !(text_q[0].drain && kmer_exp_q.size() > 0)
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    byte_ch.valid <= 1'b1;
                    byte_ch.char_byte <= text_q[0].ch;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest expected result.
    always @(posedge i_clk) begin : check_kmers
        t_kmer_res e;
        if (!i_rst_n) begin
            kmer_ch.ready <= 1'b0;
        end else begin
            if (kmer_ch.valid && kmer_ch.ready) begin
                if (kmer_exp_q.size() == 0) begin
                    $error("k-mer result with no byte waiting for it");
                    errors++;
                end else begin
                    e = kmer_exp_q.pop_front();
                    check_field("kmer_valid", 64'(e.kmer_valid), 64'(kmer_ch.kmer_valid));
                    check_field("kmer_bits", e.kmer_bits, kmer_ch.kmer_bits);
                    check_field("absolute_count", 64'(e.absolute_count),
                                64'(kmer_ch.absolute_count));
                    check_field("sequence_count", 64'(e.sequence_count),
                                64'(kmer_ch.sequence_count));
                    check_field("status", 64'(e.status), 64'(kmer_ch.status));
                    check_field("skipped_flag", 64'(e.skipped_flag),
                                64'(kmer_ch.skipped_flag));
                end
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                kmer_ch.ready <= 1'b0;
            end else if (hold_grant != hold_req) begin
                hold_grant <= hold_req;
                hold_left <= HOLD_CYCLES;
                kmer_ch.ready <= 1'b0;
            end else begin
                kmer_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (kmer_ch.valid && kmer_ch.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("fasta_kmer_extractor: mismatch");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [CHAR_W-1:0] c, input logic drain = 1'b0);
        t_text_byte t;
        t.ch = c;
        t.drain = drain;
        text_q.push_back(t);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    // One FASTA record with random content; a few bytes of noise now and then.
    task automatic push_record();
        string bases;
        string degens;
        string seps;
        int    n_lines;
        int    n_chars;
        int    roll;
        bases = "ACGTacgt";
        degens = "WSPYKMBDHVNwspykmbdhvn";
        seps = " .-";
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 5)) push_byte(CHAR_W'($urandom_range(0, 255)));
        end
        push_byte(CH_GT);
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 9) == 0) begin
                push_byte(CHAR_W'($urandom_range(128, 255)));
            end else begin
                push_byte(CHAR_W'($urandom_range(33, 126)));
            end
        end
        push_byte(CH_NL);
        n_lines = $urandom_range(1, 4);
        for (int l = 0; l < n_lines; l++) begin
            n_chars = $urandom_range(0, 30);
            for (int i = 0; i < n_chars; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 86) begin
                    push_byte(bases[$urandom_range(0, 7)]);
                end else if (roll < 91) begin
                    push_byte(degens[$urandom_range(0, 21)]);
                end else if (roll < 95) begin
                    push_byte(seps[$urandom_range(0, 2)]);
                end else if (roll < 97) begin
                    push_byte(CH_GT);
                end else begin
                    push_byte(CHAR_W'($urandom_range(0, 255)));
                end
            end
            push_byte(CH_NL);
        end
    endtask

    task automatic wait_idle();
        while (text_q.size() > 0 || kmer_exp_q.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_klen(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        klen = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus: reset, then phases of k and idling patterns.
    initial begin
        logic [CFG_W-1:0] k_plan[NUM_PHASES];
        int phase_start;
        byte_ch.valid = 1'b0;
        byte_ch.char_byte = '0;
        kmer_ch.ready = 1'b0;
        klen = KMER_LEN_RESET;
        p_mode = MODE_PRE;
        p_line_start = 1'b1;
        p_window = '0;
        p_fill = 0;
        p_seq_len = '0;
        p_counter = '0;
        p_offset = '0;
        k_plan = '{6'd3, 6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd17, 6'd2, 6'd31};
        k_plan[7] = CFG_W'($urandom_range(0, 63));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p < 3) begin
                send_idle_pct = 21;
                recv_idle_pct = 84;
            end else if (p < 6) begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_klen(k_plan[p]);
            if (p == 0) begin
                // Text before the first header, a '>' inside a line and inside
                // a header, every kind of byte in a sequence, then a '>' inside a sequence line.
                push_text("\na>\n>h>\nACGTacgtN .-");
                push_byte(8'hFF);
                push_byte(8'h0D);
                push_byte(8'h00);
                push_text("RG>\n");
            end
            if (p == 6) begin
                hold_req++;
            end
            phase_start = text_q.size();
            while (text_q.size() - phase_start < PHASE_BYTES) begin
                push_record();
                // Mid-phase, the sender pauses until every result is back.
                if (p == 4 && text_q.size() - phase_start > PHASE_BYTES / 2
                        && text_q.size() - phase_start < PHASE_BYTES / 2 + 40) begin
                    push_byte(CH_NL, 1'b1);
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("fasta_kmer_extractor: match");
        end else begin
            $display("fasta_kmer_extractor: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fkx_pkg.sv
rtl/core/fkx_if.sv
rtl/core/fkx_front.sv
rtl/core/fkx_queue.sv
rtl/core/fkx_back.sv
rtl/core/fasta_kmer_extractor.sv
tb/sv/tb.sv
